### sv/jsu_pkg.sv
// Shared types, result codes and UTF-8 encoder for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_BYTES   = 6;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_END_ESC    = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
    localparam logic [2:0] ERR_UNTERM     = 3'd5;

    // One classified input word: bytes to emit, then an optional terminal result.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic [1:0]                term_kind;
        logic [2:0]                term_code;
    } jsu_cmd_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } jsu_utf8_t;

    function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
        jsu_utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.n        = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.n        = 3'd2;
            r.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.n        = 3'd3;
            r.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            r.n        = 3'd4;
            r.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//  Channel | Handshake        | Word
//  --------+------------------+----------------------------------------------
//  in      | push / full      | data_byte, end_of_text
//  out     | empty / pop      | out_byte, kind, error_code, last_of_run
//
//  A raw byte is taken every cycle while the command queue has room; the front
//  end classifies it in the cycle it arrives.
//  Results leave at one word per cycle while pop is held; a byte that yields k
//  results (1 to 6) stays at the queue head until all are popped; a queue of
//  QUEUE_DEPTH commands absorbs bursts; bytes with no result never enter it.
//  Reset clears the parser state and the queue at once; no clearing pass.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last_of_run
);

    logic     accept;
    jsu_cmd_t cmd;
    logic     cmd_valid;
    jsu_cmd_t head;
    logic     head_done;

    assign accept = push && !full;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid)
    );

    jsu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && cmd_valid),
        .wr_cmd (cmd),
        .full   (full),
        .rd_en  (head_done),
        .head   (head),
        .empty  (empty)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_empty  (empty),
        .head_done   (head_done),
        .pop         (pop),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    // a completion or error word always closes its run
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind != KIND_BYTE |-> last_of_run)
        else $error("terminal result not last of run");

    a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match kind");

    // the rest of a run is already queued
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last_of_run |=> !empty)
        else $error("run broken after pop");

    a_byte_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind != KIND_BYTE |-> out_byte == 8'h00)
        else $error("nonzero byte on status result");

endmodule

`default_nettype wire

### sv/jsu_front.sv
// Front end: parses one raw byte per cycle while accept is high and builds its result command.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire logic [7:0] data_byte,
    input  wire logic     end_of_text,
    output jsu_cmd_t      cmd,
    output logic          cmd_valid
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] accum_reg, accum_next;
    logic [1:0]  count_reg, count_next;
    logic [9:0]  held_reg, held_next;
    logic        pending_reg, pending_next;

    logic        flush;
    logic        main_en;
    logic        main_raw;
    logic [7:0]  raw_byte;
    logic [20:0] main_cp;
    logic [1:0]  term_kind;
    logic [2:0]  term_code;
    logic [4:0]  hex_digit;
    logic [8:0]  esc_byte;
    logic [15:0] hex_cp;
    jsu_utf8_t   flush_enc;
    jsu_utf8_t   main_enc;
    logic [3:0][7:0] main_bytes;
    logic [2:0]  main_n;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h37);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    // bit 8 set means the escape letter is not recognized
    function automatic logic [8:0] escape_value(input logic [7:0] b);
        logic [8:0] v;
        unique case (b)
            8'h22:   v = 9'h022;
            8'h5c:   v = 9'h05c;
            8'h2f:   v = 9'h02f;
            8'h62:   v = 9'h008;
            8'h66:   v = 9'h00c;
            8'h6e:   v = 9'h00a;
            8'h72:   v = 9'h00d;
            8'h74:   v = 9'h009;
            default: v = 9'h100;
        endcase
        return v;
    endfunction

    assign hex_digit = hex_value(data_byte);
    assign esc_byte  = escape_value(data_byte);
    assign hex_cp    = {accum_reg[11:0], hex_digit[3:0]};

    always_comb
    begin
        mode_next    = mode_reg;
        accum_next   = accum_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        pending_next = pending_reg;
        flush        = 1'b0;
        main_en      = 1'b0;
        main_raw     = 1'b0;
        raw_byte     = data_byte;
        main_cp      = '0;
        term_kind    = KIND_BYTE;
        term_code    = ERR_NONE;

        unique case (mode_reg)
            MODE_STR:
            begin
                if (end_of_text) begin
                    flush     = pending_reg;
                    term_kind = KIND_ERROR;
                    term_code = ERR_UNTERM;
                    mode_next = MODE_IDLE;
                end else if (data_byte == 8'h5c) begin
                    mode_next = MODE_ESC;
                end else begin
                    flush = pending_reg;
                    if (data_byte == 8'h22) begin
                        term_kind = KIND_DONE;
                        mode_next = MODE_IDLE;
                    end else begin
                        main_en  = 1'b1;
                        main_raw = 1'b1;
                    end
                end
            end
            MODE_ESC:
            begin
                if (end_of_text) begin
                    flush     = pending_reg;
                    term_kind = KIND_ERROR;
                    term_code = ERR_END_ESC;
                    mode_next = MODE_IDLE;
                end else if (data_byte == 8'h75) begin
                    mode_next  = MODE_HEX;
                    accum_next = '0;
                    count_next = '0;
                end else begin
                    flush = pending_reg;
                    if (esc_byte[8]) begin
                        term_kind = KIND_ERROR;
                        term_code = ERR_BAD_ESC;
                        mode_next = MODE_IDLE;
                    end else begin
                        main_en   = 1'b1;
                        main_raw  = 1'b1;
                        raw_byte  = esc_byte[7:0];
                        mode_next = MODE_STR;
                    end
                end
            end
            MODE_HEX:
            begin
                if (end_of_text || hex_digit[4]) begin
                    // drop a held high surrogate silently
                    term_kind = KIND_ERROR;
                    term_code = ERR_BAD_HEX;
                    mode_next = MODE_IDLE;
                end else if (count_reg != 2'd3) begin
                    accum_next = hex_cp;
                    count_next = count_reg + 2'd1;
                end else begin
                    accum_next = '0;
                    count_next = '0;
                    mode_next  = MODE_STR;
                    if (pending_reg && hex_cp[15:10] == 6'b110111) begin
                        main_en      = 1'b1;
                        main_cp      = 21'h10000 + 21'({held_reg, hex_cp[9:0]});
                        pending_next = 1'b0;
                        held_next    = '0;
                    end else begin
                        flush = pending_reg;
                        if (hex_cp[15:10] == 6'b110110) begin
                            pending_next = 1'b1;
                            held_next    = hex_cp[9:0];
                        end else begin
                            pending_next = 1'b0;
                            held_next    = '0;
                            main_en      = 1'b1;
                            main_cp      = {5'b00000, hex_cp};
                        end
                    end
                end
            end
            default:
            begin
                if (!end_of_text) begin
                    if (data_byte == 8'h22) begin
                        mode_next = MODE_STR;
                    end else begin
                        term_kind = KIND_ERROR;
                        term_code = ERR_NO_QUOTE;
                        mode_next = MODE_IDLE;
                    end
                end
            end
        endcase

        if (flush) begin
            pending_next = (mode_reg == MODE_HEX) ? pending_next : 1'b0;
            held_next    = (mode_reg == MODE_HEX) ? held_next : '0;
        end
        if (mode_next == MODE_IDLE) begin
            accum_next   = '0;
            count_next   = '0;
            held_next    = '0;
            pending_next = 1'b0;
        end
    end

    assign flush_enc = utf8_encode({5'b00000, 6'b110110, held_reg});
    assign main_enc  = utf8_encode(main_cp);

    always_comb
    begin
        if (main_raw) begin
            main_bytes    = '0;
            main_bytes[0] = raw_byte;
            main_n        = 3'd1;
        end else begin
            main_bytes = main_enc.bytes;
            main_n     = main_enc.n;
        end
        if (!main_en) begin
            main_n = 3'd0;
        end
    end

    always_comb
    begin
        cmd = '0;
        if (flush) begin
            cmd.bytes[0] = flush_enc.bytes[0];
            cmd.bytes[1] = flush_enc.bytes[1];
            cmd.bytes[2] = flush_enc.bytes[2];
            cmd.bytes[3] = main_bytes[0];
            cmd.bytes[4] = main_bytes[1];
            cmd.bytes[5] = main_bytes[2];
            cmd.nbytes   = 3'd3 + main_n;
        end else begin
            cmd.bytes[0] = main_bytes[0];
            cmd.bytes[1] = main_bytes[1];
            cmd.bytes[2] = main_bytes[2];
            cmd.bytes[3] = main_bytes[3];
            cmd.nbytes   = main_n;
        end
        cmd.term_kind = term_kind;
        cmd.term_code = term_code;
    end

    assign cmd_valid = (cmd.nbytes != 3'd0) || (term_kind != KIND_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            accum_reg   <= '0;
            count_reg   <= '0;
            held_reg    <= '0;
            pending_reg <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            accum_reg   <= accum_next;
            count_reg   <= count_next;
            held_reg    <= held_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

### sv/jsu_queue.sv
// Command queue between the parsing front end and the result sequencer.
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire jsu_cmd_t wr_cmd,
    output logic          full,
    input  wire logic     rd_en,
    output jsu_cmd_t      head,
    output logic          empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    jsu_cmd_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (rd_en) begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/jsu_back.sv
// Back end: walks the head command and hands out one result word per pop.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire jsu_cmd_t head,
    input  wire logic     head_empty,
    output logic          head_done,
    input  wire logic     pop,
    output logic [7:0]    out_byte,
    output logic [1:0]    kind,
    output logic [2:0]    error_code,
    output logic          last_of_run
);

    logic [2:0] idx_reg;
    logic [2:0] total;

    assign total = head.nbytes + {2'b00, head.term_kind != KIND_BYTE};

    always_comb
    begin
        if (idx_reg < head.nbytes) begin
            out_byte   = head.bytes[idx_reg];
            kind       = KIND_BYTE;
            error_code = ERR_NONE;
        end else begin
            out_byte   = 8'h00;
            kind       = head.term_kind;
            error_code = head.term_code;
        end
    end

    assign last_of_run = (idx_reg == total - 3'd1);
    assign head_done   = pop && !head_empty && last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else if (pop && !head_empty) begin
            // advance within the command, rewind when it is used up
            idx_reg <= last_of_run ? 3'd0 : idx_reg + 3'd1;
        end
    end

endmodule

`default_nettype wire

### tb/tb_json_string_unescape_utf8.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_TAIL = 60;
    localparam int TAIL_CYCLES = 20;

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5c;
    localparam logic [7:0] CH_U   = 8'h75;

    typedef enum logic [1:0] {WAIT_QUOTE, IN_STRING, AFTER_BSLASH, IN_HEX} scan_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } out_word_t;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       drain;
    } raw_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last_of_run;

    json_string_unescape_utf8 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    raw_item_t raw_text[$];
    out_word_t due_words[$];
    out_word_t run_words[$];
    out_word_t seen_word;
    out_word_t due_word;
    logic      hold_next = 1'b0;
    string     esc_letters = "\"\\/bfnrt";

    // Shadow state of the decoder
    scan_t       scan = WAIT_QUOTE;
    logic [15:0] hex_acc = '0;
    logic [1:0]  hex_n = '0;
    logic [9:0]  held_bits = '0;
    logic        held_valid = 1'b0;

    logic in_fire = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   stall_cycles = 0;
    int   fail_count = 0;
    int   n_bytes_in = 0;
    int   n_words_out = 0;
    int   n_closed = 0;
    int   n_faults = 0;
    int   n_pairs = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return 5'(b - "0");
        if (b >= "a" && b <= "f")
            return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F")
            return 5'(b - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [8:0] escape_code(input logic [7:0] b);
        case (b)
            QUOTE:  return {1'b0, QUOTE};
            BSLASH: return {1'b0, BSLASH};
            "/":    return 9'h02f;
            "b":    return 9'h008;
            "f":    return 9'h00c;
            "n":    return 9'h00a;
            "r":    return 9'h00d;
            "t":    return 9'h009;
            default: return 9'h100;
        endcase
    endfunction

    task automatic put_word(input logic [7:0] v, input logic [1:0] k, input logic [2:0] c);
        out_word_t w;
        w.value = v;
        w.kind  = k;
        w.code  = c;
        w.last  = 1'b0;
        run_words.insert(run_words.size(), w);
    endtask

    task automatic put_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            put_word(cp[7:0], KIND_BYTE, ERR_NONE);
        end
        else if (cp < 21'h800)
        begin
            put_word(8'hc0 | 8'(cp >> 6), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
        end
        else if (cp < 21'h10000)
        begin
            put_word(8'he0 | 8'(cp >> 12), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
        end
        else
        begin
            put_word(8'hf0 | 8'((cp >> 18) & 21'h7), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'((cp >> 12) & 21'h3f), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE);
            put_word(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
        end
    endtask

    task automatic flush_held();
        if (held_valid)
        begin
            put_code_point(21'hd800 + held_bits);
            held_valid = 1'b0;
            held_bits  = '0;
        end
    endtask

    task automatic go_idle();
        scan       = WAIT_QUOTE;
        hex_acc    = '0;
        hex_n      = '0;
        held_bits  = '0;
        held_valid = 1'b0;
    endtask

    task automatic raise_error(input logic [2:0] c);
        put_word(8'h00, KIND_ERROR, c);
        go_idle();
    endtask

    task automatic take_code_point(input logic [15:0] cp);
        if (cp >= 16'hd800 && cp <= 16'hdbff)
        begin
            held_bits  = 10'(cp - 16'hd800);
            held_valid = 1'b1;
        end
        else
        begin
            put_code_point({5'b0, cp});
        end
    endtask

    // Work out the words one accepted input byte must produce
    task automatic predict_unescape(input logic [7:0] b, input logic eot);
        logic [4:0]  d;
        logic [8:0]  e;
        logic [15:0] cp;
        run_words.delete();
        case (scan)
            IN_STRING:
            begin
                if (eot)
                begin
                    flush_held();
                    raise_error(ERR_UNTERM);
                end
                else if (b == BSLASH)
                begin
                    scan = AFTER_BSLASH;
                end
                else
                begin
                    flush_held();
                    if (b == QUOTE)
                    begin
                        put_word(8'h00, KIND_DONE, ERR_NONE);
                        go_idle();
                    end
                    else
                    begin
                        put_word(b, KIND_BYTE, ERR_NONE);
                    end
                end
            end
            AFTER_BSLASH:
            begin
                if (eot)
                begin
                    flush_held();
                    raise_error(ERR_END_ESC);
                end
                else if (b == CH_U)
                begin
                    scan    = IN_HEX;
                    hex_acc = '0;
                    hex_n   = '0;
                end
                else
                begin
                    e = escape_code(b);
                    flush_held();
                    if (e[8])
                    begin
                        raise_error(ERR_BAD_ESC);
                    end
                    else
                    begin
                        put_word(e[7:0], KIND_BYTE, ERR_NONE);
                        scan = IN_STRING;
                    end
                end
            end
            IN_HEX:
            begin
                d = hex_digit(b);
                if (eot || d[4])
                begin
                    // drop any held high surrogate silently
                    raise_error(ERR_BAD_HEX);
                end
                else
                begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_n < 2'd3)
                    begin
                        hex_n = hex_n + 2'd1;
                    end
                    else
                    begin
                        cp      = hex_acc;
                        hex_acc = '0;
                        hex_n   = '0;
                        scan    = IN_STRING;
                        if (held_valid && cp >= 16'hdc00 && cp <= 16'hdfff)
                        begin
                            put_code_point(21'h10000 + {held_bits, 10'b0} + (cp - 16'hdc00));
                            held_valid = 1'b0;
                            held_bits  = '0;
                            n_pairs++;
                        end
                        else
                        begin
                            flush_held();
                            take_code_point(cp);
                        end
                    end
                end
            end
            default:
            begin
                if (!eot)
                begin
                    if (b == QUOTE)
                    begin
                        go_idle();
                        scan = IN_STRING;
                    end
                    else
                    begin
                        raise_error(ERR_NO_QUOTE);
                    end
                end
            end
        endcase
        if (run_words.size() != 0)
            run_words[run_words.size() - 1].last = 1'b1;
        foreach (run_words[i])
            due_words.insert(due_words.size(), run_words[i]);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eot);
        raw_item_t it;
        it.data   = b;
        it.eot    = eot;
        it.drain  = hold_next;
        hold_next = 1'b0;
        raw_text.insert(raw_text.size(), it);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            add_byte(s[i], 1'b0);
    endtask

    task automatic add_hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            add_byte(8'("0" + n), 1'b0);
        else if ($urandom_range(0, 1))
            add_byte(8'("A" + n - 10), 1'b0);
        else
            add_byte(8'("a" + n - 10), 1'b0);
    endtask

    task automatic add_hex_escape(input logic [15:0] v);
        add_byte(BSLASH, 1'b0);
        add_byte(CH_U, 1'b0);
        add_hex_digit(v[15:12]);
        add_hex_digit(v[11:8]);
        add_hex_digit(v[7:4]);
        add_hex_digit(v[3:0]);
    endtask

    function automatic logic [15:0] bmp_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 'h7f));
            1: return 16'($urandom_range('h80, 'h7ff));
            2: return 16'($urandom_range('h800, 'hd7ff));
            3: return 16'($urandom_range('hdc00, 'hdfff));
            default: return 16'($urandom_range('he000, 'hffff));
        endcase
    endfunction

    function automatic logic [15:0] high_value();
        return 16'($urandom_range('hd800, 'hdbff));
    endfunction

    task automatic add_piece();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                b = 8'($urandom_range('h20, 'h7e));
                if (b == QUOTE || b == BSLASH)
                    b = 8'h20;
                add_byte(b, 1'b0);
            end
            2, 3:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == QUOTE || b == BSLASH);
                add_byte(b, 1'b0);
            end
            4, 5:
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(esc_letters[$urandom_range(0, 7)], 1'b0);
            end
            6, 7:
                add_hex_escape(bmp_value());
            8, 9:
            begin
                add_hex_escape(high_value());
                add_hex_escape(16'($urandom_range('hdc00, 'hdfff)));
            end
            10:
                add_hex_escape(high_value());
            default:
            begin
                // held high surrogate, then a second escape that may not pair
                add_hex_escape(high_value());
                add_hex_escape($urandom_range(0, 1) ? high_value() : bmp_value());
            end
        endcase
    endtask

    task automatic add_string();
        int         ending;
        logic [7:0] b;
        logic [8:0] e;
        logic [4:0] d;
        add_byte(QUOTE, 1'b0);
        repeat ($urandom_range(0, 6))
            add_piece();
        ending = $urandom_range(0, 11);
        if (ending >= 7 && $urandom_range(0, 2) == 0)
            add_hex_escape(high_value());
        case (ending)
            7:
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            8:
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            9:
            begin
                add_byte(BSLASH, 1'b0);
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    e = escape_code(b);
                end
                while (!e[8] || b == CH_U);
                add_byte(b, 1'b0);
            end
            10, 11:
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(CH_U, 1'b0);
                repeat ($urandom_range(0, 3))
                    add_hex_digit(4'($urandom_range(0, 15)));
                if (ending == 11)
                begin
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                else
                begin
                    do
                    begin
                        b = 8'($urandom_range(0, 255));
                        d = hex_digit(b);
                    end
                    while (!d[4]);
                    add_byte(b, 1'b0);
                end
            end
            default:
                add_byte(QUOTE, 1'b0);
        endcase
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 4) == 0)
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            else
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    function automatic bit quiet_tail();
        return raw_text.size() < CALM_TAIL;
    endfunction

    // Input driver: hold the word until taken, insert idle bursts between words
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (in_gap != 0)
        begin
            in_gap <= in_gap - 1;
            push   <= 1'b0;
        end
        else if (!push || in_fire)
        begin
            if (raw_text.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (raw_text[0].drain && due_words.size() != 0)
            begin
                push <= 1'b0;
            end
            else if (!quiet_tail() && $urandom_range(0, 7) == 0)
            begin
                in_gap <= $urandom_range(0, 9);
                push   <= 1'b0;
            end
            else
            begin
                push        <= 1'b1;
                data_byte   <= raw_text[0].data;
                end_of_text <= raw_text[0].eot;
            end
        end
    end

    // Result side: pop with random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (out_gap != 0)
        begin
            out_gap <= out_gap - 1;
            pop     <= 1'b0;
        end
        else if (!quiet_tail() && $urandom_range(0, 9) == 0)
        begin
            out_gap <= $urandom_range(0, 9);
            pop     <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Monitor: check result words, then predict from accepted input words
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= push && !full;
            if (pop && !empty)
            begin
                seen_word = '{out_byte, kind, error_code, last_of_run};
                n_words_out++;
                if (kind == KIND_DONE)
                    n_closed++;
                if (kind == KIND_ERROR)
                    n_faults++;
                if (due_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected word byte=%h kind=%0d code=%0d last=%0d",
                                 $time, out_byte, kind, error_code, last_of_run);
                    fail_count++;
                end
                else
                begin
                    due_word = due_words.pop_front();
                    if (seen_word.value !== due_word.value || seen_word.kind !== due_word.kind
                        || seen_word.code !== due_word.code || seen_word.last !== due_word.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("%0t: mismatch exp byte=%h kind=%0d code=%0d last=%0d",
                                   $time, due_word.value, due_word.kind, due_word.code,
                                   due_word.last);
                            $display(" got byte=%h kind=%0d code=%0d last=%0d",
                                     out_byte, kind, error_code, last_of_run);
                        end
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                predict_unescape(data_byte, end_of_text);
                raw_text.delete(0);
                n_bytes_in++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int next_pause;
        int stop_at;
        // directed: idle cases, byte extremes, max supplementary pair, error paths
        add_byte(8'h00, 1'b1);
        add_text("a");
        add_text("\"");
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_text("\\uDBff\\udFFF\"");
        add_text("\"\\q");
        add_text("\"\\");
        add_byte(8'hff, 1'b1);
        add_text("\"\\ug");
        add_text("\"");
        add_byte(8'h00, 1'b1);

        hold_next  = 1'b1;
        next_pause = raw_text.size() + 100;
        stop_at    = RANDOM_ITEMS;
        while (raw_text.size() < stop_at)
        begin
            if (raw_text.size() >= next_pause)
            begin
                hold_next  = 1'b1;
                next_pause = next_pause + 100;
            end
            if ($urandom_range(0, 4) == 0)
                add_noise();
            else
                add_string();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (raw_text.size() != 0 || due_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_words.size() != 0)
        begin
            $display("%0d expected words never arrived", due_words.size());
            fail_count += due_words.size();
        end

        $display("Covered %0d input bytes and %0d result words (%0d strings closed, %0d errors).",
                 n_bytes_in, n_words_out, n_closed, n_faults);
        $display("Surrogate pairs joined: %0d; failures counted: %0d.", n_pairs, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
